### design/alu_xf_pkg.sv
// Shared types and constants for the XNZVC integer ALU.
`default_nettype none

package alu_xf_pkg;

    localparam int CMD_W  = 5;
    localparam int SIZE_W = 2;
    localparam int DATA_W = 32;
    localparam int CCR_W  = 5;

    // Operation codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 5'd0;
    localparam logic [CMD_W-1:0] CMD_SUB    = 5'd1;
    localparam logic [CMD_W-1:0] CMD_ADDX   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SUBX   = 5'd3;
    localparam logic [CMD_W-1:0] CMD_NEG    = 5'd4;
    localparam logic [CMD_W-1:0] CMD_NEGX   = 5'd5;
    localparam logic [CMD_W-1:0] CMD_AND    = 5'd6;
    localparam logic [CMD_W-1:0] CMD_OR     = 5'd7;
    localparam logic [CMD_W-1:0] CMD_EOR    = 5'd8;
    localparam logic [CMD_W-1:0] CMD_NOT    = 5'd9;
    localparam logic [CMD_W-1:0] CMD_CLR    = 5'd10;
    localparam logic [CMD_W-1:0] CMD_ADDA   = 5'd11;
    localparam logic [CMD_W-1:0] CMD_SUBA   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_EXTW   = 5'd13;
    localparam logic [CMD_W-1:0] CMD_EXTL   = 5'd14;
    localparam logic [CMD_W-1:0] CMD_EXTB   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_SWAP   = 5'd16;
    localparam logic [CMD_W-1:0] CMD_ORCCR  = 5'd17;
    localparam logic [CMD_W-1:0] CMD_ANDCCR = 5'd18;
    localparam logic [CMD_W-1:0] CMD_EORCCR = 5'd19;

    // Operand size codes; the unused code behaves as long
    localparam logic [SIZE_W-1:0] OPSZ_BYTE = 2'd0;
    localparam logic [SIZE_W-1:0] OPSZ_WORD = 2'd1;
    localparam logic [SIZE_W-1:0] OPSZ_LONG = 2'd2;

    // Flag bit positions
    localparam int FLAG_X = 4;
    localparam int FLAG_N = 3;
    localparam int FLAG_Z = 2;
    localparam int FLAG_V = 1;
    localparam int FLAG_C = 0;

    localparam logic [DATA_W-1:0] MASK_BYTE = 32'h0000_00FF;
    localparam logic [DATA_W-1:0] MASK_WORD = 32'h0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_LONG = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] SIGN_BYTE = 32'h0000_0080;
    localparam logic [DATA_W-1:0] SIGN_WORD = 32'h0000_8000;
    localparam logic [DATA_W-1:0] SIGN_LONG = 32'h8000_0000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] size;
        logic [DATA_W-1:0] src;
        logic [DATA_W-1:0] dst;
        logic [CCR_W-1:0]  ccr;
    } alu_xf_op_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [CCR_W-1:0]  ccr;
        logic              writes_dest;
    } alu_xf_res_t;

endpackage

`default_nettype wire

### design/alu_xf_core.sv
// Combinational datapath: one operation in, new destination and flags out.
`default_nettype none

module alu_xf_core (
    input  wire  alu_xf_pkg::alu_xf_op_t  op,
    output alu_xf_pkg::alu_xf_res_t       res
);
    import alu_xf_pkg::*;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] sbit;
    logic              xin;

    // shared add/subtract unit
    logic [DATA_W-1:0] a_op;
    logic [DATA_W-1:0] b_op;
    logic              do_sub;
    logic              cin;
    logic [DATA_W-1:0] am;
    logic [DATA_W-1:0] bm;
    logic [DATA_W:0]   sum33;
    logic [DATA_W-1:0] ar;
    logic              ar_c;
    logic              ar_v;
    logic              ar_n;
    logic              ar_z;

    logic [DATA_W-1:0] lr;
    logic [DATA_W-1:0] addr_v;
    logic [15:0]       extw_w;
    logic [DATA_W-1:0] long_r;

    always_comb
    begin
        case (op.size)
            OPSZ_BYTE:
            begin
                mask = MASK_BYTE;
                sbit = SIGN_BYTE;
            end
            OPSZ_WORD:
            begin
                mask = MASK_WORD;
                sbit = SIGN_WORD;
            end
            default:
            begin
                mask = MASK_LONG;
                sbit = SIGN_LONG;
            end
        endcase
    end

    assign xin = op.ccr[FLAG_X];

    always_comb
    begin
        a_op   = op.dst;
        b_op   = op.src;
        do_sub = 1'b0;
        cin    = 1'b0;
        case (op.cmd)
            CMD_ADDX:
            begin
                cin = xin;
            end
            CMD_SUB:
            begin
                do_sub = 1'b1;
            end
            CMD_SUBX:
            begin
                do_sub = 1'b1;
                cin    = xin;
            end
            CMD_NEG:
            begin
                a_op   = '0;
                b_op   = op.dst;
                do_sub = 1'b1;
            end
            CMD_NEGX:
            begin
                a_op   = '0;
                b_op   = op.dst;
                do_sub = 1'b1;
                cin    = xin;
            end
            default:
            begin
                a_op = op.dst;
            end
        endcase
    end

    assign am = a_op & mask;
    assign bm = b_op & mask;

    always_comb
    begin
        if (do_sub)
            sum33 = {1'b0, am} - {1'b0, bm} - {{DATA_W{1'b0}}, cin};
        else
            sum33 = {1'b0, am} + {1'b0, bm} + {{DATA_W{1'b0}}, cin};
    end

    assign ar = sum33[DATA_W-1:0] & mask;

    // borrow always shows in the top bit; carry sits just above the operand size
    always_comb
    begin
        if (do_sub)
            ar_c = sum33[DATA_W];
        else
        begin
            case (op.size)
                OPSZ_BYTE: ar_c = sum33[8];
                OPSZ_WORD: ar_c = sum33[16];
                default:   ar_c = sum33[DATA_W];
            endcase
        end
    end

    always_comb
    begin
        if (do_sub)
            ar_v = |((am ^ bm) & (am ^ ar) & sbit);
        else
            ar_v = |(~(a_op ^ b_op) & (a_op ^ ar) & sbit);
    end

    assign ar_n = |(ar & sbit);
    assign ar_z = (ar == '0);

    always_comb
    begin
        case (op.cmd)
            CMD_AND: lr = op.dst & op.src;
            CMD_OR:  lr = op.dst | op.src;
            CMD_EOR: lr = op.dst ^ op.src;
            CMD_NOT: lr = ~op.dst;
            default: lr = '0;
        endcase
    end

    assign addr_v = (op.size == OPSZ_BYTE || op.size == OPSZ_WORD)
                  ? {{16{op.src[15]}}, op.src[15:0]} : op.src;
    assign extw_w = {{8{op.dst[7]}}, op.dst[7:0]};

    always_comb
    begin
        case (op.cmd)
            CMD_EXTL: long_r = {{16{op.dst[15]}}, op.dst[15:0]};
            CMD_EXTB: long_r = {{24{op.dst[7]}}, op.dst[7:0]};
            default:  long_r = {op.dst[15:0], op.dst[31:16]};
        endcase
    end

    always_comb
    begin
        res.result      = op.dst;
        res.ccr         = op.ccr;
        res.writes_dest = 1'b1;
        case (op.cmd)
            CMD_ADD, CMD_SUB, CMD_NEG:
            begin
                res.result = (op.dst & ~mask) | ar;
                res.ccr    = {ar_c, ar_n, ar_z, ar_v, ar_c};
            end
            CMD_ADDX, CMD_SUBX, CMD_NEGX:
            begin
                // Z only ever gets cleared
                res.result = (op.dst & ~mask) | ar;
                res.ccr    = {ar_c, ar_n, ar_z & op.ccr[FLAG_Z], ar_v, ar_c};
            end
            CMD_AND, CMD_OR, CMD_EOR, CMD_NOT, CMD_CLR:
            begin
                res.result = (op.dst & ~mask) | (lr & mask);
                res.ccr    = {xin, |(lr & sbit), ((lr & mask) == '0), 1'b0, 1'b0};
            end
            CMD_ADDA:
            begin
                res.result = op.dst + addr_v;
            end
            CMD_SUBA:
            begin
                res.result = op.dst - addr_v;
            end
            CMD_EXTW:
            begin
                res.result = {op.dst[31:16], extw_w};
                res.ccr    = {xin, extw_w[15], (extw_w == '0), 1'b0, 1'b0};
            end
            CMD_EXTL, CMD_EXTB, CMD_SWAP:
            begin
                res.result = long_r;
                res.ccr    = {xin, long_r[31], (long_r == '0), 1'b0, 1'b0};
            end
            CMD_ORCCR:
            begin
                res.ccr         = op.ccr | op.src[CCR_W-1:0];
                res.writes_dest = 1'b0;
            end
            CMD_ANDCCR:
            begin
                res.ccr         = op.ccr & op.src[CCR_W-1:0];
                res.writes_dest = 1'b0;
            end
            CMD_EORCCR:
            begin
                res.ccr         = op.ccr ^ op.src[CCR_W-1:0];
                res.writes_dest = 1'b0;
            end
            default:
            begin
                res.writes_dest = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/alu_with_extended_flags.sv
// Top level of the integer ALU with XNZVC condition codes.
// Takes one operation word per cycle and returns one result word per cycle
// while the result side does not stall; each word passes through an operand
// register, then the datapath, then a result register. Throughput is one word
// per clock while out_ready holds and is set by the single-pass datapath
// between those two registers; in_ready only drops while both registers hold
// words and the result side stalls.
// Byte and word add, subtract, negate and logic results keep the upper bits
// of dst; flag-only operations return dst unchanged with writes_dest low.
`default_nettype none

module alu_with_extended_flags (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [alu_xf_pkg::CMD_W-1:0]      cmd,
    input  wire  [alu_xf_pkg::SIZE_W-1:0]     size,
    input  wire  [alu_xf_pkg::DATA_W-1:0]     src,
    input  wire  [alu_xf_pkg::DATA_W-1:0]     dst,
    input  wire  [alu_xf_pkg::CCR_W-1:0]      ccr_in,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [alu_xf_pkg::DATA_W-1:0]     result,
    output logic [alu_xf_pkg::CCR_W-1:0]      ccr_out,
    output logic                              writes_dest
);
    import alu_xf_pkg::*;

    alu_xf_op_t  op_reg;
    logic        op_valid_reg;
    logic        op_valid_next;
    alu_xf_res_t res_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    alu_xf_res_t core_res;

    logic        in_take;
    logic        op_move;

    assign op_move  = op_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !op_valid_reg || op_move;
    assign in_take  = in_valid && in_ready;

    assign op_valid_next  = in_take || (op_valid_reg && !op_move);
    assign res_valid_next = op_move || (res_valid_reg && !out_ready);

    alu_xf_core u_core (
        .op  (op_reg),
        .res (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            op_reg <= '{cmd: cmd, size: size, src: src, dst: dst, ccr: ccr_in};
        if (op_move)
            res_reg <= core_res;
    end

    assign out_valid   = res_valid_reg;
    assign result      = res_reg.result;
    assign ccr_out     = res_reg.ccr;
    assign writes_dest = res_reg.writes_dest;

endmodule

`default_nettype wire

### design/alu_xf_checker.sv
// Port-level checker for the ALU and its bind to the top level.
`default_nettype none

module alu_xf_checker (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_valid,
    input  wire                               in_ready,
    input  wire                               out_valid,
    input  wire                               out_ready,
    input  wire  [alu_xf_pkg::DATA_W-1:0]     result,
    input  wire  [alu_xf_pkg::CCR_W-1:0]      ccr_out,
    input  wire                               writes_dest
);

    // an empty result register means the operand stage can always drain
    a_ready_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready
    ) else $error("in_ready low with no result pending");

    // a taken word reaches the output once the result side is open
    a_word_arrives: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready |=> out_valid
    ) else $error("accepted word did not reach the output");

    // a stalled result word holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(result) && $stable(ccr_out) && $stable(writes_dest))
    ) else $error("result word changed while stalled");

endmodule

bind alu_with_extended_flags alu_xf_checker u_alu_xf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result),
    .ccr_out     (ccr_out),
    .writes_dest (writes_dest)
);

`default_nettype wire
